// ----- src/picut_pkg.sv -----
`timescale 1ns / 1ps

package picut_pkg;

    // Field widths used by the payload structs.
    localparam int TIME_WIDTH         = 32;
    localparam int COUNT_WIDTH        = 16;
    localparam int PROGRESS_FRAC_BITS = 16;

    // Default accumulator width handed to the top level.
    localparam int ACC_WIDTH_DEFAULT = 48;

    // Period length after reset.
    localparam logic [TIME_WIDTH-1:0] INTERVAL_RESET = TIME_WIDTH'(1000);

    // Command codes.
    localparam logic [2:0] OP_UPDATE  = 3'd0;
    localparam logic [2:0] OP_START   = 3'd1;
    localparam logic [2:0] OP_RESTART = 3'd2;
    localparam logic [2:0] OP_PAUSE   = 3'd3;
    localparam logic [2:0] OP_RESUME  = 3'd4;
    localparam logic [2:0] OP_RESET   = 3'd5;

    // One command transaction.
    typedef struct packed {
        logic [2:0]             op;
        logic [TIME_WIDTH-1:0]  delta_ticks;
        logic [COUNT_WIDTH-1:0] max_catch_up;
    } picut_cmd_t;

    // One result transaction.
    typedef struct packed {
        logic                        accepted;
        logic [COUNT_WIDTH-1:0]      occurrences;
        logic [TIME_WIDTH-1:0]       ticks_until_next;
        logic [PROGRESS_FRAC_BITS:0] progress;
        logic                        started_flag;
        logic                        running_flag;
    } picut_res_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic exec;
        logic div_step;
        logic fix;
        logic prog_load;
        logic out_load;
    } picut_dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_div;
        logic prog_div;
    } picut_dp_sts_t;

endpackage

// ----- src/periodic_interval_catch_up_timer.sv -----
`timescale 1ns / 1ps

// Periodic interval timer with catch-up in integer ticks. One command transaction gives
// exactly one result transaction. An update of a running timer with a nonzero limit divides
// for the occurrence count, and the progress fraction is divided only when the timer is
// started and the progress is not full. Both use one shared restoring divider that retires
// one quotient bit per cycle; limit times period is built by a serial multiplier during the
// same division steps. One command is worked on at a time, and the next is accepted while a
// finished result still waits in the output register.
// Interval writes of zero are ignored; a write while not started also sets the active period.
module periodic_interval_catch_up_timer #(
    parameter int ACC_WIDTH = picut_pkg::ACC_WIDTH_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cmd_valid,
    output logic                                 cmd_ready,
    input  picut_pkg::picut_cmd_t                cmd,
    output logic                                 res_valid,
    input  logic                                 res_ready,
    output picut_pkg::picut_res_t                res,
    input  logic                                 cfg_we,
    input  logic [picut_pkg::TIME_WIDTH-1:0]     cfg_wdata
);

    picut_pkg::picut_dp_cmd_t ctl;
    picut_pkg::picut_dp_sts_t sts;

    // Command sequencer.
    picut_ctrl #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    // Timer state, divider and result register.
    picut_dp #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .ctl       (ctl),
        .sts       (sts),
        .res       (res)
    );

`ifndef ASSERT_OFF
    // A command is worked on alone: no second transaction right after one is taken.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready) |=> !cmd_ready)
        else $error("command accepted while the previous one is still in progress");

    // Occurrences only come from an accepted update of a running timer.
    a_occ_running: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (res.occurrences != '0)) |-> (res.accepted && res.running_flag))
        else $error("occurrences reported without an accepted running update");

    // A stopped timer reports no progress and is not running.
    a_not_started: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res.started_flag) |-> ((res.progress == '0) && !res.running_flag))
        else $error("timer not started but reports progress or running");

    // Progress never passes one.
    a_progress_max: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.progress <= {1'b1, {picut_pkg::PROGRESS_FRAC_BITS{1'b0}}}))
        else $error("progress above one");
`endif

endmodule

// ----- src/picut_dp.sv -----
`timescale 1ns / 1ps

module picut_dp #(
    parameter int ACC_WIDTH = picut_pkg::ACC_WIDTH_DEFAULT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  picut_pkg::picut_cmd_t    cmd,
    input  logic                     cfg_we,
    input  logic [picut_pkg::TIME_WIDTH-1:0] cfg_wdata,
    input  picut_pkg::picut_dp_cmd_t ctl,
    output picut_pkg::picut_dp_sts_t sts,
    output picut_pkg::picut_res_t    res
);

    localparam int TW = picut_pkg::TIME_WIDTH;
    localparam int CW = picut_pkg::COUNT_WIDTH;
    localparam int FB = picut_pkg::PROGRESS_FRAC_BITS;

    // Timer state.
    logic [TW-1:0]        interval_reg, interval_next;
    logic [TW-1:0]        active_reg, active_next;
    logic [ACC_WIDTH-1:0] acc_reg, acc_next;
    logic                 started_reg, started_next;
    logic                 running_reg, running_next;

    // Captured command and working registers.
    logic [2:0]           op_reg;
    logic [TW-1:0]        delta_reg;
    logic [CW-1:0]        limit_reg;
    logic                 ok_reg;
    logic [CW-1:0]        occ_reg;
    logic [ACC_WIDTH-1:0] sum_reg;
    logic [TW-1:0]        rem_reg;
    logic [ACC_WIDTH-1:0] quot_reg;
    logic [ACC_WIDTH-1:0] prod_reg;
    logic [ACC_WIDTH-1:0] mcand_reg;
    logic [CW-1:0]        lim_sh_reg;
    picut_pkg::picut_res_t res_reg;

    logic                 ok_exec;
    logic                 latch_exec;
    logic [ACC_WIDTH:0]   sum_wide;
    logic [ACC_WIDTH-1:0] sum_sat;
    logic [TW:0]          shifted;
    logic [TW:0]          d_ext;
    logic                 ge;
    logic [TW-1:0]        rem_step;
    logic [ACC_WIDTH-1:0] active_acc;
    logic                 cap;
    logic [CW-1:0]        occ_fix;
    logic [ACC_WIDTH-1:0] acc_fix;
    logic                 below;
    logic [TW-1:0]        ticks_left;
    logic [FB:0]          progress;

    // Saturating sum of the accumulator and the elapsed ticks.
    assign sum_wide = {1'b0, acc_reg} + (ACC_WIDTH + 1)'(delta_reg);
    assign sum_sat  = sum_wide[ACC_WIDTH] ? {ACC_WIDTH{1'b1}} : sum_wide[ACC_WIDTH-1:0];

    // One restoring division step, shared by the update and the progress fraction.
    assign shifted  = {rem_reg, quot_reg[ACC_WIDTH-1]};
    assign d_ext    = {1'b0, active_reg};
    assign ge       = shifted >= d_ext;
    assign rem_step = ge ? TW'(shifted - d_ext) : shifted[TW-1:0];

    // Catch-up limit: keep the whole remainder or take off limit times the period.
    assign active_acc = ACC_WIDTH'(active_reg);
    assign cap        = quot_reg >= ACC_WIDTH'(limit_reg);
    assign occ_fix    = cap ? limit_reg : quot_reg[CW-1:0];
    assign acc_fix    = cap ? (sum_reg - prod_reg) : ACC_WIDTH'(rem_reg);

    // Result fields derived from the state after the command.
    assign below = acc_reg < active_acc;
    always_comb
    begin
        if (!started_reg)
        begin
            ticks_left = interval_reg;
            progress   = '0;
        end
        else if (below)
        begin
            ticks_left = TW'(active_acc - acc_reg);
            progress   = {1'b0, quot_reg[FB-1:0]};
        end
        else
        begin
            ticks_left = '0;
            progress   = {1'b1, {FB{1'b0}}};
        end
    end

    assign sts.need_div = (op_reg == picut_pkg::OP_UPDATE) && (limit_reg != '0) && running_reg;
    assign sts.prog_div = started_reg && below;

    // Command decode and next timer state.
    always_comb
    begin
        interval_next = interval_reg;
        active_next   = active_reg;
        acc_next      = acc_reg;
        started_next  = started_reg;
        running_next  = running_reg;
        ok_exec       = 1'b0;
        latch_exec    = 1'b0;

        if (cfg_we && (cfg_wdata != '0))
        begin
            interval_next = cfg_wdata;
            if (!started_reg)
            begin
                active_next = cfg_wdata;
            end
        end

        if (ctl.exec)
        begin
            unique case (op_reg)
                picut_pkg::OP_UPDATE:
                begin
                    ok_exec = limit_reg != '0;
                end
                picut_pkg::OP_START:
                begin
                    if (!started_reg)
                    begin
                        ok_exec      = 1'b1;
                        latch_exec   = 1'b1;
                        started_next = 1'b1;
                        running_next = 1'b1;
                    end
                end
                picut_pkg::OP_RESTART:
                begin
                    ok_exec      = 1'b1;
                    latch_exec   = 1'b1;
                    started_next = 1'b1;
                    running_next = 1'b1;
                end
                picut_pkg::OP_PAUSE:
                begin
                    if (running_reg)
                    begin
                        ok_exec      = 1'b1;
                        running_next = 1'b0;
                    end
                end
                picut_pkg::OP_RESUME:
                begin
                    if (started_reg && !running_reg)
                    begin
                        ok_exec      = 1'b1;
                        running_next = 1'b1;
                    end
                end
                picut_pkg::OP_RESET:
                begin
                    ok_exec      = 1'b1;
                    latch_exec   = 1'b1;
                    started_next = 1'b0;
                    running_next = 1'b0;
                end
                default:
                begin
                    ok_exec = 1'b0;
                end
            endcase
            if (latch_exec)
            begin
                active_next = interval_reg;
                acc_next    = '0;
            end
        end

        if (ctl.fix)
        begin
            acc_next = acc_fix;
        end
    end

    // Timer state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= picut_pkg::INTERVAL_RESET;
            active_reg   <= picut_pkg::INTERVAL_RESET;
            acc_reg      <= '0;
            started_reg  <= 1'b0;
            running_reg  <= 1'b0;
        end
        else
        begin
            interval_reg <= interval_next;
            active_reg   <= active_next;
            acc_reg      <= acc_next;
            started_reg  <= started_next;
            running_reg  <= running_next;
        end
    end

    // Working registers: command capture, divider, serial multiplier and result.
    always_ff @(posedge clk)
    begin
        if (ctl.load_item)
        begin
            op_reg    <= cmd.op;
            delta_reg <= cmd.delta_ticks;
            limit_reg <= cmd.max_catch_up;
        end

        if (ctl.exec)
        begin
            ok_reg     <= ok_exec;
            occ_reg    <= '0;
            sum_reg    <= sum_sat;
            quot_reg   <= sum_sat;
            rem_reg    <= '0;
            prod_reg   <= '0;
            mcand_reg  <= active_acc;
            lim_sh_reg <= limit_reg;
        end
        else if (ctl.div_step)
        begin
            rem_reg    <= rem_step;
            quot_reg   <= {quot_reg[ACC_WIDTH-2:0], ge};
            prod_reg   <= prod_reg + (lim_sh_reg[0] ? mcand_reg : '0);
            mcand_reg  <= {mcand_reg[ACC_WIDTH-2:0], 1'b0};
            lim_sh_reg <= {1'b0, lim_sh_reg[CW-1:1]};
        end
        else if (ctl.prog_load)
        begin
            rem_reg  <= acc_reg[TW-1:0];
            quot_reg <= '0;
        end

        if (ctl.fix)
        begin
            occ_reg <= occ_fix;
        end

        if (ctl.out_load)
        begin
            res_reg.accepted         <= ok_reg;
            res_reg.occurrences      <= occ_reg;
            res_reg.ticks_until_next <= ticks_left;
            res_reg.progress         <= progress;
            res_reg.started_flag     <= started_reg;
            res_reg.running_flag     <= running_reg;
        end
    end

    assign res = res_reg;

endmodule

// ----- src/picut_ctrl.sv -----
`timescale 1ns / 1ps

module picut_ctrl #(
    parameter int ACC_WIDTH = picut_pkg::ACC_WIDTH_DEFAULT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cmd_valid,
    output logic                     cmd_ready,
    output logic                     res_valid,
    input  logic                     res_ready,
    input  picut_pkg::picut_dp_sts_t sts,
    output picut_pkg::picut_dp_cmd_t ctl
);

    localparam int CNT_W = $clog2(ACC_WIDTH);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_FIX   = 3'd3;
    localparam logic [2:0] S_PLOAD = 3'd4;
    localparam logic [2:0] S_PROG  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             valid_reg, valid_next;
    logic             slot_free;

    assign slot_free = !valid_reg || res_ready;

    // Sequencer for one command: execute, divide, apply the limit, then the fraction.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ctl        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    ctl.load_item = 1'b1;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC:
            begin
                ctl.exec = 1'b1;
                if (sts.need_div)
                begin
                    cnt_next   = CNT_W'(ACC_WIDTH - 1);
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_PLOAD;
                end
            end
            S_DIV:
            begin
                ctl.div_step = 1'b1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = S_FIX;
                end
            end
            S_FIX:
            begin
                ctl.fix    = 1'b1;
                state_next = S_PLOAD;
            end
            S_PLOAD:
            begin
                ctl.prog_load = 1'b1;
                if (sts.prog_div)
                begin
                    cnt_next   = CNT_W'(picut_pkg::PROGRESS_FRAC_BITS - 1);
                    state_next = S_PROG;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_PROG:
            begin
                ctl.div_step = 1'b1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register valid flag.
    always_comb
    begin
        valid_next = valid_reg;
        if (ctl.out_load)
        begin
            valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    assign cmd_ready = state_reg == S_IDLE;
    assign res_valid = valid_reg;

endmodule
